### rtl/fqa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqa_pkg
// Shared types, constants and helpers of the aggregating FIFO queue.
// ----------------------------------------------------------------------------
package fqa_pkg;

  // Queue geometry (DEPTH is a power of two)
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = $clog2(DEPTH);

  // Field widths of the transaction payloads
  localparam int CMD_W   = 2;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 5;
  localparam int SUM_W   = 36;

  // Capacity after reset
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_CLR = 2'd2,
    CMD_NOP = 2'd3
  } cmd_t;

  // Status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } stat_t;

  // Sequencer states
  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_DEQ,
    FSM_SCAN,
    FSM_DIV,
    FSM_DONE
  } fsm_t;

  // Input transaction
  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] value;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic [CNT_W-1:0]          held_count;
    logic signed [SUM_W-1:0]   total;
    logic signed [VALUE_W-1:0] smallest;
    logic signed [VALUE_W-1:0] largest;
    logic signed [VALUE_W-1:0] mean;
  } out_t;

  // Sign-extend one stored entry to the sum width
  function automatic logic signed [SUM_W-1:0] sext_data(logic [DATA_WIDTH-1:0] v);
    return {{(SUM_W-DATA_WIDTH){v[DATA_WIDTH-1]}}, v};
  endfunction

  // Advance a ring pointer with wrap at DEPTH
  function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH-1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

### rtl/fqa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqa_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fqa_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/fqa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqa_div
// Serial restoring divider: signed sum by unsigned count, one bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module fqa_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [fqa_pkg::SUM_W-1:0]  dividend,
  input  logic [fqa_pkg::CNT_W-1:0]         divisor,
  output logic                              done,
  output logic signed [fqa_pkg::VALUE_W-1:0] quotient
);

  localparam int ITER_W = $clog2(fqa_pkg::SUM_W + 1);

  logic                          run_r,  run_nxt;
  logic                          done_r, done_nxt;
  logic                          neg_r,  neg_nxt;
  logic [ITER_W-1:0]             iter_r, iter_nxt;
  logic [fqa_pkg::SUM_W-1:0]     quo_r,  quo_nxt;
  logic [fqa_pkg::CNT_W-1:0]     rem_r,  rem_nxt;
  logic [fqa_pkg::CNT_W-1:0]     dsr_r,  dsr_nxt;
  logic [fqa_pkg::CNT_W:0]       rem_sh;
  logic [fqa_pkg::SUM_W-1:0]     quo_signed;

  // Shift in one dividend bit and trial-subtract
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    iter_nxt = iter_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    rem_sh   = {rem_r, quo_r[fqa_pkg::SUM_W-1]};
    if (start) begin
      run_nxt  = 1'b1;
      neg_nxt  = dividend[fqa_pkg::SUM_W-1];
      quo_nxt  = dividend[fqa_pkg::SUM_W-1] ? -dividend : dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      iter_nxt = ITER_W'(fqa_pkg::SUM_W);
    end else if (run_r) begin
      if (rem_sh >= {1'b0, dsr_r}) begin
        rem_nxt = fqa_pkg::CNT_W'(rem_sh - {1'b0, dsr_r});
        quo_nxt = {quo_r[fqa_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[fqa_pkg::CNT_W-1:0];
        quo_nxt = {quo_r[fqa_pkg::SUM_W-2:0], 1'b0};
      end
      iter_nxt = iter_r - ITER_W'(1);
      if (iter_r == ITER_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    neg_r  <= neg_nxt;
    iter_r <= iter_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
  end

  // Restore the sign of the quotient
  assign quo_signed = neg_r ? -quo_r : quo_r;
  assign quotient   = quo_signed[fqa_pkg::VALUE_W-1:0];
  assign done       = done_r;

endmodule

### rtl/fifo_queue_with_aggregates_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_aggregates_core
// Bounded FIFO of signed values that reports count, sum, min, max and mean.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_data (cmd, value) and pulse start while busy is low; the
//   command is taken at that edge and busy stays high until the result.
//   Commands: enqueue, dequeue oldest, clear, and a no-op code.
//   One result per command appears on out_data for a single cycle, flagged
//   by out_valid; there is no backpressure, the receiver must take it.
//   cfg_we/cfg_wdata set the capacity (saturated at the queue depth); write
//   it only while busy is low.
// Sequence: a command updates the queue as it is taken, a dequeue first
//   reading its oldest entry. The min/max rescan then reads the entry RAM
//   once per held entry through its single read port, and the mean comes
//   from a one-bit-per-cycle divider over the 36-bit sum; an empty queue
//   skips both and reports zeros. busy drops the cycle after out_valid,
//   and no new command is taken before then.
// Reset: rst_n (synchronous, active low) empties the queue, zeroes the
//   pointers and sum, and restores a capacity of 16. The entry RAM is not
//   cleared; only held entries are ever read.
// ----------------------------------------------------------------------------
module fifo_queue_with_aggregates_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  fqa_pkg::in_t                in_data,
  output logic                        out_valid,
  output fqa_pkg::out_t               out_data,
  input  logic                        cfg_we,
  input  logic [fqa_pkg::CNT_W-1:0]   cfg_wdata
);

  fqa_pkg::fsm_t                         state_r, state_nxt;
  logic [fqa_pkg::PTR_W-1:0]             rptr_r, rptr_nxt;
  logic [fqa_pkg::PTR_W-1:0]             wptr_r, wptr_nxt;
  logic [fqa_pkg::CNT_W-1:0]             cnt_r, cnt_nxt;
  logic signed [fqa_pkg::SUM_W-1:0]      sum_r, sum_nxt;
  logic [fqa_pkg::CNT_W-1:0]             cap_r, cap_nxt;
  logic [fqa_pkg::STAT_W-1:0]            status_r, status_nxt;
  logic [fqa_pkg::PTR_W-1:0]             scan_ptr_r, scan_ptr_nxt;
  logic [fqa_pkg::CNT_W-1:0]             left_r, left_nxt;
  logic                                  pend_r, pend_nxt;
  logic                                  first_r, first_nxt;
  logic signed [fqa_pkg::DATA_WIDTH-1:0] lo_r, lo_nxt;
  logic signed [fqa_pkg::DATA_WIDTH-1:0] hi_r, hi_nxt;
  logic signed [fqa_pkg::VALUE_W-1:0]    mean_r, mean_nxt;

  logic [fqa_pkg::CNT_W-1:0]             limit;
  logic                                  enter_agg;
  logic                                  ram_we;
  logic                                  ram_re;
  logic [fqa_pkg::PTR_W-1:0]             ram_raddr;
  logic [fqa_pkg::DATA_WIDTH-1:0]        ram_rdata;
  logic signed [fqa_pkg::DATA_WIDTH-1:0] entry;
  logic                                  div_start;
  logic                                  div_done;
  logic signed [fqa_pkg::VALUE_W-1:0]    div_quo;

  // Entry store
  fqa_ram #(
    .DEPTH (fqa_pkg::DEPTH),
    .WIDTH (fqa_pkg::DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wptr_r),
    .wdata (in_data.value[fqa_pkg::DATA_WIDTH-1:0]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Mean divider
  fqa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign entry = $signed(ram_rdata);
  assign limit = (cap_r > fqa_pkg::CNT_W'(fqa_pkg::DEPTH)) ?
                 fqa_pkg::CNT_W'(fqa_pkg::DEPTH) : cap_r;

  // Sequence one command: update, rescan, divide, report; an empty queue skips to the report
  always_comb begin
    state_nxt    = state_r;
    rptr_nxt     = rptr_r;
    wptr_nxt     = wptr_r;
    cnt_nxt      = cnt_r;
    sum_nxt      = sum_r;
    cap_nxt      = cfg_we ? cfg_wdata : cap_r;
    status_nxt   = status_r;
    scan_ptr_nxt = scan_ptr_r;
    left_nxt     = left_r;
    pend_nxt     = pend_r;
    first_nxt    = first_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    mean_nxt     = mean_r;
    enter_agg    = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = scan_ptr_r;
    div_start    = 1'b0;
    out_valid    = 1'b0;

    unique case (state_r)
      fqa_pkg::FSM_IDLE: begin
        if (start) begin
          status_nxt = fqa_pkg::STAT_OK;
          unique case (fqa_pkg::cmd_t'(in_data.cmd))
            fqa_pkg::CMD_ENQ: begin
              enter_agg = 1'b1;
              if (cnt_r >= limit) begin
                status_nxt = fqa_pkg::STAT_FULL;
              end else begin
                ram_we   = 1'b1;
                wptr_nxt = fqa_pkg::next_ptr(wptr_r);
                cnt_nxt  = cnt_r + fqa_pkg::CNT_W'(1);
                sum_nxt  = sum_r +
                           fqa_pkg::sext_data(in_data.value[fqa_pkg::DATA_WIDTH-1:0]);
              end
            end
            fqa_pkg::CMD_DEQ: begin
              if (cnt_r == '0) begin
                status_nxt = fqa_pkg::STAT_EMPTY;
                enter_agg  = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = rptr_r;
                state_nxt = fqa_pkg::FSM_DEQ;
              end
            end
            fqa_pkg::CMD_CLR: begin
              rptr_nxt  = '0;
              wptr_nxt  = '0;
              cnt_nxt   = '0;
              sum_nxt   = '0;
              enter_agg = 1'b1;
            end
            fqa_pkg::CMD_NOP: begin
              enter_agg = 1'b1;
            end
          endcase
        end
      end
      fqa_pkg::FSM_DEQ: begin
        // Oldest entry is on the read port now: drop it from the sum
        sum_nxt   = sum_r - fqa_pkg::sext_data(ram_rdata);
        rptr_nxt  = fqa_pkg::next_ptr(rptr_r);
        cnt_nxt   = cnt_r - fqa_pkg::CNT_W'(1);
        enter_agg = 1'b1;
      end
      fqa_pkg::FSM_SCAN: begin
        // Issue one read per held entry, fold returning data into min/max
        pend_nxt = (left_r != '0);
        if (left_r != '0) begin
          ram_re       = 1'b1;
          scan_ptr_nxt = fqa_pkg::next_ptr(scan_ptr_r);
          left_nxt     = left_r - fqa_pkg::CNT_W'(1);
        end
        if (pend_r) begin
          first_nxt = 1'b0;
          if (first_r) begin
            lo_nxt = entry;
            hi_nxt = entry;
          end else begin
            if (entry < lo_r) lo_nxt = entry;
            if (entry > hi_r) hi_nxt = entry;
          end
        end
        if ((left_r == '0) && !pend_r) begin
          div_start = 1'b1;
          state_nxt = fqa_pkg::FSM_DIV;
        end
      end
      fqa_pkg::FSM_DIV: begin
        if (div_done) begin
          mean_nxt  = div_quo;
          state_nxt = fqa_pkg::FSM_DONE;
        end
      end
      fqa_pkg::FSM_DONE: begin
        out_valid = 1'b1;
        state_nxt = fqa_pkg::FSM_IDLE;
      end
      default: begin
        state_nxt = fqa_pkg::FSM_IDLE;
      end
    endcase

    // Start the aggregate pass, or report zeros for an empty queue
    if (enter_agg) begin
      scan_ptr_nxt = rptr_nxt;
      left_nxt     = cnt_nxt;
      pend_nxt     = 1'b0;
      first_nxt    = 1'b1;
      if (cnt_nxt != '0) begin
        state_nxt = fqa_pkg::FSM_SCAN;
      end else begin
        state_nxt = fqa_pkg::FSM_DONE;
        sum_nxt   = '0;
        lo_nxt    = '0;
        hi_nxt    = '0;
        mean_nxt  = '0;
      end
    end
  end

  // State and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fqa_pkg::FSM_IDLE;
      rptr_r  <= '0;
      wptr_r  <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
      cap_r   <= fqa_pkg::CAP_RESET;
      left_r  <= '0;
      pend_r  <= 1'b0;
      first_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      rptr_r  <= rptr_nxt;
      wptr_r  <= wptr_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      cap_r   <= cap_nxt;
      left_r  <= left_nxt;
      pend_r  <= pend_nxt;
      first_r <= first_nxt;
    end
    status_r   <= status_nxt;
    scan_ptr_r <= scan_ptr_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mean_r     <= mean_nxt;
  end

  // Result transaction
  assign busy                = (state_r != fqa_pkg::FSM_IDLE);
  assign out_data.status     = status_r;
  assign out_data.held_count = cnt_r;
  assign out_data.total      = sum_r;
  assign out_data.smallest   = fqa_pkg::VALUE_W'(lo_r);
  assign out_data.largest    = fqa_pkg::VALUE_W'(hi_r);
  assign out_data.mean       = mean_r;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the aggregating FIFO queue core.
// A short directed table covers reset state, value extremes, every command,
// refusals and capacity corner cases. Random command bursts follow under
// several capacity settings and pacing modes. Every result transaction is
// compared field by field with its directed expectation or the in-bench queue mirror.
// ----------------------------------------------------------------------------
module tb;
  import fqa_pkg::*;

  localparam int CYCLE_LIMIT  = 800000;
  localparam int SEG_ITEMS    = 165;
  localparam int NUM_SEGMENTS = 8;

  // One row of the directed table: a capacity write or a command
  typedef struct packed {
    logic             is_cfg;
    logic [CNT_W-1:0] cap;
    logic             typed;
    in_t              item;
    out_t             exp;
  } step_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_t              in_data;
  logic             out_valid;
  out_t             out_data;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  // Typed expectation travelling with the command being offered
  logic             typed_valid;
  out_t             typed_exp;

  // Queue mirror
  logic signed [VALUE_W-1:0] mirror_store [DEPTH];
  int                        mirror_rd;
  int                        mirror_wr;
  int                        mirror_count;
  longint                    mirror_sum;
  logic [CNT_W-1:0]          mirror_cap;

  out_t   pending_results [$];
  step_t  dir_steps [$];
  int     idle_pct;
  int     n_sent;
  int     n_checked;
  int     n_full;
  int     n_empty;
  int     errors;
  int     cycles;

  fifo_queue_with_aggregates_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Apply one command to the mirror and return the result it should produce
  function automatic out_t queue_apply(in_t t);
    out_t                      r;
    int                        lim;
    int                        p;
    logic signed [VALUE_W-1:0] lo;
    logic signed [VALUE_W-1:0] hi;
    r = '0;
    lim = (mirror_cap > DEPTH) ? DEPTH : int'(mirror_cap);
    r.status = STAT_OK;
    case (t.cmd)
      CMD_ENQ: begin
        if (mirror_count >= lim) begin
          r.status = STAT_FULL;
        end else begin
          mirror_store[mirror_wr] = t.value;
          mirror_wr = (mirror_wr + 1) % DEPTH;
          mirror_count++;
          mirror_sum += longint'(t.value);
        end
      end
      CMD_DEQ: begin
        if (mirror_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          mirror_sum -= longint'(mirror_store[mirror_rd]);
          mirror_rd = (mirror_rd + 1) % DEPTH;
          mirror_count--;
        end
      end
      CMD_CLR: begin
        mirror_rd = 0;
        mirror_wr = 0;
        mirror_count = 0;
        mirror_sum = 0;
      end
      default: ;
    endcase
    r.held_count = CNT_W'(mirror_count);
    if (mirror_count > 0) begin
      // Rescan held entries from the oldest
      p = mirror_rd;
      lo = mirror_store[p];
      hi = lo;
      for (int i = 0; i < mirror_count; i++) begin
        if (mirror_store[p] < lo) lo = mirror_store[p];
        if (mirror_store[p] > hi) hi = mirror_store[p];
        p = (p + 1) % DEPTH;
      end
      r.total = SUM_W'(mirror_sum);
      r.smallest = lo;
      r.largest = hi;
      r.mean = VALUE_W'(mirror_sum / longint'(mirror_count));
    end else begin
      mirror_sum = 0;
    end
    return r;
  endfunction

  function automatic void log_error(string msg);
    if (errors < 10) $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endfunction

  // Check results, track capacity writes, predict accepted commands
  always @(posedge clk) begin : monitor
    out_t want;
    out_t got;
    if (!rst_n) begin
      mirror_rd = 0;
      mirror_wr = 0;
      mirror_count = 0;
      mirror_sum = 0;
      mirror_cap = CAP_RESET;
    end else begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          log_error("result transaction with nothing expected");
        end else begin
          want = pending_results.pop_front();
          n_checked++;
          if (out_data.status == STAT_FULL) n_full++;
          if (out_data.status == STAT_EMPTY) n_empty++;
          if (out_data.status !== want.status || out_data.held_count !== want.held_count ||
              out_data.total !== want.total || out_data.smallest !== want.smallest ||
              out_data.largest !== want.largest || out_data.mean !== want.mean) begin
            log_error({$sformatf("exp st=%0d n=%0d sum=%0d min=%0d max=%0d avg=%0d",
                                 want.status, want.held_count, want.total,
                                 want.smallest, want.largest, want.mean),
                       $sformatf(" | got st=%0d n=%0d sum=%0d min=%0d max=%0d avg=%0d",
                                 out_data.status, out_data.held_count, out_data.total,
                                 out_data.smallest, out_data.largest, out_data.mean)});
          end
        end
      end
      if (cfg_we) mirror_cap = cfg_wdata;
      if (start && !busy) begin
        got = queue_apply(in_data);
        pending_results.push_back(typed_valid ? typed_exp : got);
      end
    end
  end

  function automatic in_t mk(logic [CMD_W-1:0] c, logic [VALUE_W-1:0] v);
    in_t t;
    t.cmd = c;
    t.value = v;
    return t;
  endfunction

  function automatic out_t agg(stat_t s, int n, longint tot, logic [VALUE_W-1:0] lo,
                               logic [VALUE_W-1:0] hi, logic [VALUE_W-1:0] avg);
    out_t r;
    r.status = s;
    r.held_count = CNT_W'(n);
    r.total = SUM_W'(tot);
    r.smallest = lo;
    r.largest = hi;
    r.mean = avg;
    return r;
  endfunction

  function automatic step_t op(logic [CMD_W-1:0] c, logic [VALUE_W-1:0] v);
    step_t s;
    s = '0;
    s.item = mk(c, v);
    return s;
  endfunction

  function automatic step_t op_exp(logic [CMD_W-1:0] c, logic [VALUE_W-1:0] v, out_t e);
    step_t s;
    s = op(c, v);
    s.typed = 1'b1;
    s.exp = e;
    return s;
  endfunction

  function automatic step_t cap_set(logic [CNT_W-1:0] c);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.cap = c;
    return s;
  endfunction

  // Mostly random values, with the extremes and small numbers favored
  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return VALUE_W'(int'($urandom_range(20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  // Offer one command after a random idle gap; hold it until taken
  task automatic issue(in_t t, logic typed, out_t e);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= t;
    typed_valid <= typed;
    typed_exp <= e;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  // Write the capacity once the queue core has drained
  task automatic write_cap(logic [CNT_W-1:0] c);
    start <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0 || busy) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= c;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random bursts: fill runs, drain runs, mixed commands, clears and no-ops
  task automatic run_segment(int n_items);
    int                 target;
    int                 len;
    int                 mode;
    logic [VALUE_W-1:0] fixed_v;
    target = n_sent + n_items;
    while (n_sent < target) begin
      mode = $urandom_range(9);
      len = $urandom_range(1, 18);
      fixed_v = rand_value();
      case (mode)
        0, 1, 2, 3: begin
          for (int i = 0; i < len; i++)
            issue(mk(CMD_ENQ, (mode == 0) ? fixed_v : rand_value()), 1'b0, '0);
        end
        4, 5, 6: begin
          for (int i = 0; i < len; i++) issue(mk(CMD_DEQ, $urandom), 1'b0, '0);
        end
        7: begin
          for (int i = 0; i < len / 2 + 1; i++)
            issue(mk(CMD_W'($urandom_range(3)), rand_value()), 1'b0, '0);
        end
        8: issue(mk(CMD_CLR, $urandom), 1'b0, '0);
        default: issue(mk(CMD_NOP, $urandom), 1'b0, '0);
      endcase
    end
  endtask

  initial begin : stimulus
    logic [CNT_W-1:0] caps [NUM_SEGMENTS];
    int               pacing [4];
    caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd2, 5'd12};
    pacing = '{0, 56, 0, 26};
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    typed_valid = 1'b0;
    typed_exp = '0;
    idle_pct = 0;
    n_sent = 0;
    n_checked = 0;
    n_full = 0;
    n_empty = 0;
    errors = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table
    dir_steps = '{
      op_exp(CMD_DEQ, 32'd0, agg(STAT_EMPTY, 0, 0, 0, 0, 0)),
      op_exp(CMD_NOP, 32'hFFFF_FFFF, agg(STAT_OK, 0, 0, 0, 0, 0)),
      op_exp(CMD_ENQ, 32'h7FFF_FFFF, agg(STAT_OK, 1, 64'sh7FFF_FFFF, 32'h7FFF_FFFF,
                                         32'h7FFF_FFFF, 32'h7FFF_FFFF)),
      op(CMD_ENQ, 32'h8000_0000),
      op(CMD_ENQ, 32'hFFFF_FFFF),
      op(CMD_NOP, 32'h5555_AAAA),
      op(CMD_DEQ, 32'hAAAA_5555),
      op_exp(CMD_CLR, 32'd12345, agg(STAT_OK, 0, 0, 0, 0, 0)),
      op_exp(CMD_DEQ, 32'd0, agg(STAT_EMPTY, 0, 0, 0, 0, 0)),
      cap_set(5'd0),
      op_exp(CMD_ENQ, 32'd5, agg(STAT_FULL, 0, 0, 0, 0, 0)),
      cap_set(5'd31),
      op_exp(CMD_ENQ, -32'sd7, agg(STAT_OK, 1, -64'sd7, -32'sd7, -32'sd7, -32'sd7)),
      op(CMD_ENQ, 32'd3),
      cap_set(5'd1),
      op(CMD_ENQ, 32'd9),
      op(CMD_DEQ, 32'd0),
      op(CMD_ENQ, 32'd11),
      op(CMD_DEQ, 32'd0),
      cap_set(5'd2),
      op(CMD_ENQ, 32'h8000_0000),
      op(CMD_ENQ, 32'h8000_0000),
      op(CMD_ENQ, 32'h7FFF_FFFF),
      op_exp(CMD_CLR, 32'd0, agg(STAT_OK, 0, 0, 0, 0, 0))
    };
    foreach (dir_steps[k]) begin
      if (dir_steps[k].is_cfg) write_cap(dir_steps[k].cap);
      else issue(dir_steps[k].item, dir_steps[k].typed, dir_steps[k].exp);
    end

    // Random segments, one capacity setting and pacing mode each
    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      write_cap(caps[seg]);
      idle_pct = pacing[seg % 4];
      run_segment(SEG_ITEMS);
    end

    // Drain
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (pending_results.size() != 0) log_error("results still expected at end of run");

    $display("Ran %0d commands over %0d capacity settings and 4 pacing modes;",
             n_sent, NUM_SEGMENTS);
    $display("checked %0d results (%0d refused full, %0d refused empty), %0d mismatches.",
             n_checked, n_full, n_empty, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
